FILE: rtl/bmrm_pkg.sv
// ----------------------------------------------------------------------------
// bmrm_pkg
// Shared constants, types and arithmetic helpers of the binary merge running
// mean unit.
// ----------------------------------------------------------------------------
package bmrm_pkg;

  // configuration of the store
  localparam int LEVELS        = 32;
  localparam int SAMPLE_BITS   = 32;
  localparam int FRACTION_BITS = 16;

  // fixed field widths
  localparam int MEAN_BITS  = 48;
  localparam int COUNT_BITS = 32;
  localparam int IN_BITS    = 32;

  // derived widths
  localparam int LVL_BITS   = $clog2(LEVELS);
  localparam int ENTRY_BITS = SAMPLE_BITS + FRACTION_BITS;
  localparam int WIDE_BITS  = ((ENTRY_BITS > MEAN_BITS) ? ENTRY_BITS : MEAN_BITS) + 1;
  // weighted sum: |mean| * count stays below 2^(MEAN_BITS+COUNT_BITS-1)
  localparam int SUM_BITS   = MEAN_BITS + COUNT_BITS;
  // quotient is below 2^MEAN_BITS, two bits retire per divider cycle
  localparam int DIV_STEPS  = MEAN_BITS / 2;
  localparam int DSTEP_BITS = $clog2(DIV_STEPS);

  // count at which adds are refused
  localparam logic [COUNT_BITS-1:0] CAPACITY =
    (LEVELS >= COUNT_BITS) ? {COUNT_BITS{1'b1}}
                           : COUNT_BITS'((64'd1 << LEVELS) - 64'd1);

  // action codes
  localparam logic ACT_ADD   = 1'b0;
  localparam logic ACT_CLEAR = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RIPPLE,
    ST_WRITE,
    ST_LOAD,
    ST_DIVIDE,
    ST_ROUND,
    ST_SIGN,
    ST_RESP
  } bmrm_state_t;

  // divider request and response
  typedef struct packed {
    logic                  start;
    logic [SUM_BITS-1:0]   dividend;
    logic [COUNT_BITS-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                  done;
    logic [MEAN_BITS-1:0]  quo;
    logic [COUNT_BITS-1:0] rem;
  } div_rsp_t;

  // level-0 entry: sample scaled by 2^FRACTION_BITS, clamped to the mean range
  function automatic logic signed [MEAN_BITS-1:0] sat_entry(
    input logic signed [SAMPLE_BITS-1:0] s
  );
    logic signed [WIDE_BITS-1:0] w;
    logic signed [WIDE_BITS-1:0] hi;
    logic signed [WIDE_BITS-1:0] lo;
    w  = WIDE_BITS'(s) <<< FRACTION_BITS;
    hi = {{(WIDE_BITS-MEAN_BITS+1){1'b0}}, {(MEAN_BITS-1){1'b1}}};
    lo = ~hi;
    if (w > hi) begin
      w = hi;
    end else if (w < lo) begin
      w = lo;
    end
    return w[MEAN_BITS-1:0];
  endfunction

  // average of two equal-depth entries, round half up
  function automatic logic signed [MEAN_BITS-1:0] merge_pair(
    input logic signed [MEAN_BITS-1:0] a,
    input logic signed [MEAN_BITS-1:0] b
  );
    logic signed [MEAN_BITS:0] s;
    s = (MEAN_BITS+1)'(a) + (MEAN_BITS+1)'(b) + (MEAN_BITS+1)'(1);
    return s[MEAN_BITS:1];
  endfunction

endpackage

FILE: rtl/bmrm_ifs.sv
// ----------------------------------------------------------------------------
// bmrm_ifs
// Valid/ready channels of the running mean unit: sample words in, mean
// words out.
// ----------------------------------------------------------------------------
interface bmrm_in_if;
  logic                             valid;
  logic                             ready;
  logic                             action;
  logic signed [bmrm_pkg::IN_BITS-1:0] sample;

  modport source (output valid, output action, output sample, input ready);
  modport sink   (input valid, input action, input sample, output ready);
endinterface

interface bmrm_out_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [bmrm_pkg::MEAN_BITS-1:0] mean;
  logic [bmrm_pkg::COUNT_BITS-1:0]       sample_count;
  logic                                  accepted;

  modport source (output valid, output mean, output sample_count, output accepted,
                  input ready);
  modport sink   (input valid, input mean, input sample_count, input accepted,
                  output ready);
endinterface

FILE: rtl/bmrm_ram.sv
// ----------------------------------------------------------------------------
// bmrm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bmrm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/bmrm_div.sv
// ----------------------------------------------------------------------------
// bmrm_div
// Restoring divider, two quotient bits per cycle. Divides the weighted sum
// magnitude by the sample count; the high dividend part must be below the
// divisor, so only the low MEAN_BITS quotient bits are formed.
// ----------------------------------------------------------------------------
module bmrm_div (
  input  logic               clk,
  input  logic               rst_n,
  input  bmrm_pkg::div_req_t req,
  output bmrm_pkg::div_rsp_t rsp
);

  localparam int M = bmrm_pkg::MEAN_BITS;
  localparam int C = bmrm_pkg::COUNT_BITS;

  logic                            busy_r, busy_nxt;
  logic                            done_r, done_nxt;
  logic [bmrm_pkg::DSTEP_BITS-1:0] cnt_r, cnt_nxt;
  logic [C-1:0]                    rem_r, rem_nxt;
  logic [M-1:0]                    quo_r, quo_nxt;
  logic [C-1:0]                    div_r, div_nxt;

  logic [C:0]   t1, t2;
  logic         ge1, ge2;
  logic [C-1:0] r1, r2;
  logic [M-1:0] q1, q2;

  // two restoring steps
  always_comb begin
    t1  = {rem_r, quo_r[M-1]};
    ge1 = (t1 >= {1'b0, div_r});
    r1  = ge1 ? C'(t1 - {1'b0, div_r}) : t1[C-1:0];
    q1  = {quo_r[M-2:0], ge1};
    t2  = {r1, q1[M-1]};
    ge2 = (t2 >= {1'b0, div_r});
    r2  = ge2 ? C'(t2 - {1'b0, div_r}) : t2[C-1:0];
    q2  = {q1[M-2:0], ge2};
  end

  // sequencing
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    div_nxt  = div_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = req.dividend[bmrm_pkg::SUM_BITS-1:M];
      quo_nxt  = req.dividend[M-1:0];
      div_nxt  = req.divisor;
    end else if (busy_r) begin
      rem_nxt = r2;
      quo_nxt = q2;
      cnt_nxt = bmrm_pkg::DSTEP_BITS'(cnt_r + 1'b1);
      if (cnt_r == bmrm_pkg::DSTEP_BITS'(bmrm_pkg::DIV_STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    div_r <= div_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quo  = quo_r;
  assign rsp.rem  = rem_r;

endmodule

FILE: rtl/binary_merge_running_mean_unit.sv
// Operation: an add ripples up the low set bits of the count, one RAM
//   read-merge per level, then divides by the count in the radix-4 divider.
//   Clear and refused adds skip both steps and go straight to the result word.
//   One word at a time: the next word waits until the output register takes the last.
// Reset: synchronous, active low; clears count, weighted sum and held mean.
//   The level RAM is not cleared: slots are live only where count bits are set.
// ----------------------------------------------------------------------------
// binary_merge_running_mean_unit
// Running mean kept as binary-counter partial averages in a level RAM, with
// a register holding the 2^d-weighted sum of the occupied slots.
// ----------------------------------------------------------------------------
module binary_merge_running_mean_unit (
  input  logic       clk,
  input  logic       rst_n,
  bmrm_in_if.sink    in_ch,
  bmrm_out_if.source out_ch
);

  localparam int M = bmrm_pkg::MEAN_BITS;
  localparam int C = bmrm_pkg::COUNT_BITS;
  localparam int S = bmrm_pkg::SUM_BITS;
  localparam int L = bmrm_pkg::LVL_BITS;

  bmrm_pkg::bmrm_state_t state_r, state_nxt;

  logic [C-1:0]          count_r, count_nxt;
  logic signed [S-1:0]   wsum_r, wsum_nxt;
  logic signed [M-1:0]   mean_r, mean_nxt;
  logic signed [M-1:0]   e_r, e_nxt;
  logic [L-1:0]          lvl_r, lvl_nxt;
  logic                  acc_r, acc_nxt;
  logic                  neg_r, neg_nxt;
  logic [M:0]            qmag_r, qmag_nxt;

  logic                  out_valid_r, out_valid_nxt;
  logic signed [M-1:0]   out_mean_r, out_mean_nxt;
  logic [C-1:0]          out_count_r, out_count_nxt;
  logic                  out_acc_r, out_acc_nxt;

  logic                  ram_we;
  logic [M-1:0]          ram_rdata;

  bmrm_pkg::div_req_t    div_req;
  bmrm_pkg::div_rsp_t    div_rsp;

  // level store: read at lvl_nxt; the registered data belongs to lvl_r in the next cycle
  bmrm_ram #(
    .WIDTH (M),
    .DEPTH (bmrm_pkg::LEVELS)
  ) u_level_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (lvl_r),
    .wdata (e_r),
    .raddr (lvl_nxt),
    .rdata (ram_rdata)
  );

  bmrm_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  logic                  in_fire;
  logic [L-1:0]          lvl_inc;
  logic [C-1:0]          cnt_shift;
  logic signed [S-1:0]   term;
  logic signed [M-1:0]   slot;
  logic [S-1:0]          wsum_mag;
  logic                  round_up;
  logic [M:0]            qinc;
  logic signed [M+1:0]   sval;
  logic signed [M+1:0]   mean_hi;
  logic signed [M+1:0]   mean_lo;
  logic                  load_out;

  assign in_fire = in_ch.valid && in_ch.ready;
  assign slot    = ram_rdata;

  // next state and datapath
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    wsum_nxt      = wsum_r;
    mean_nxt      = mean_r;
    e_nxt         = e_r;
    lvl_nxt       = lvl_r;
    acc_nxt       = acc_r;
    neg_nxt       = neg_r;
    qmag_nxt      = qmag_r;
    out_valid_nxt = out_valid_r;
    out_mean_nxt  = out_mean_r;
    out_count_nxt = out_count_r;
    out_acc_nxt   = out_acc_r;
    ram_we        = 1'b0;
    div_req       = '0;
    load_out      = 1'b0;
    lvl_inc       = L'(lvl_r + 1'b1);
    cnt_shift     = '0;
    term          = '0;
    wsum_mag      = '0;
    round_up      = 1'b0;
    qinc          = '0;
    sval          = '0;
    mean_hi       = {3'b000, {(M-1){1'b1}}};
    mean_lo       = ~mean_hi;

    // output word register frees on handshake
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      bmrm_pkg::ST_IDLE: begin
        if (in_fire) begin
          lvl_nxt = '0;
          acc_nxt = 1'b1;
          if (in_ch.action == bmrm_pkg::ACT_CLEAR) begin
            count_nxt = '0;
            wsum_nxt  = '0;
            mean_nxt  = '0;
            state_nxt = bmrm_pkg::ST_RESP;
          end else if (count_r >= bmrm_pkg::CAPACITY) begin
            acc_nxt   = 1'b0;
            state_nxt = bmrm_pkg::ST_RESP;
          end else begin
            e_nxt     = bmrm_pkg::sat_entry(in_ch.sample[bmrm_pkg::SAMPLE_BITS-1:0]);
            state_nxt = count_r[0] ? bmrm_pkg::ST_RIPPLE : bmrm_pkg::ST_WRITE;
          end
        end
      end

      // carry ripple: merge occupied slot, drop its weight from the sum
      bmrm_pkg::ST_RIPPLE: begin
        e_nxt     = bmrm_pkg::merge_pair(slot, e_r);
        term      = S'(slot) <<< lvl_r;
        wsum_nxt  = wsum_r - term;
        lvl_nxt   = lvl_inc;
        cnt_shift = count_r >> lvl_inc;
        if (!cnt_shift[0]) begin
          state_nxt = bmrm_pkg::ST_WRITE;
        end
      end

      // store the carried entry, add its weight, bump the count
      bmrm_pkg::ST_WRITE: begin
        ram_we    = 1'b1;
        term      = S'(e_r) <<< lvl_r;
        wsum_nxt  = wsum_r + term;
        count_nxt = C'(count_r + 1'b1);
        state_nxt = bmrm_pkg::ST_LOAD;
      end

      // start |sum| / count
      bmrm_pkg::ST_LOAD: begin
        neg_nxt          = wsum_r[S-1];
        wsum_mag         = wsum_r[S-1] ? S'(-wsum_r) : S'(wsum_r);
        div_req.start    = 1'b1;
        div_req.dividend = wsum_mag;
        div_req.divisor  = count_r;
        state_nxt        = bmrm_pkg::ST_DIVIDE;
      end

      // round to nearest, ties away from zero, clamp magnitude
      bmrm_pkg::ST_DIVIDE: begin
        if (div_rsp.done) begin
          round_up = ({div_rsp.rem, 1'b0} >= {1'b0, count_r});
          qinc     = {1'b0, div_rsp.quo} + (M+1)'(round_up);
          qmag_nxt = (qinc > {1'b1, {M{1'b0}}} >> 1) ? ({1'b1, {M{1'b0}}} >> 1) : qinc;
          state_nxt = bmrm_pkg::ST_ROUND;
        end
      end

      // apply sign and saturate
      bmrm_pkg::ST_ROUND: begin
        sval = neg_r ? -$signed({1'b0, qmag_r}) : $signed({1'b0, qmag_r});
        if (sval > mean_hi) begin
          sval = mean_hi;
        end else if (sval < mean_lo) begin
          sval = mean_lo;
        end
        mean_nxt  = sval[M-1:0];
        state_nxt = bmrm_pkg::ST_SIGN;
      end

      bmrm_pkg::ST_SIGN: begin
        state_nxt = bmrm_pkg::ST_RESP;
      end

      // hand the word to the output register
      bmrm_pkg::ST_RESP: begin
        if (!out_valid_r || out_ch.ready) begin
          load_out      = 1'b1;
          out_valid_nxt = 1'b1;
          out_mean_nxt  = mean_r;
          out_count_nxt = count_r;
          out_acc_nxt   = acc_r;
          state_nxt     = bmrm_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = bmrm_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bmrm_pkg::ST_IDLE;
      count_r     <= '0;
      wsum_r      <= '0;
      mean_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      wsum_r      <= wsum_nxt;
      mean_r      <= mean_nxt;
      out_valid_r <= out_valid_nxt;
    end
    e_r         <= e_nxt;
    lvl_r       <= lvl_nxt;
    acc_r       <= acc_nxt;
    neg_r       <= neg_nxt;
    qmag_r      <= qmag_nxt;
    out_mean_r  <= out_mean_nxt;
    out_count_r <= out_count_nxt;
    out_acc_r   <= out_acc_nxt;
  end

  assign in_ch.ready         = (state_r == bmrm_pkg::ST_IDLE);
  assign out_ch.valid        = out_valid_r;
  assign out_ch.mean         = out_mean_r;
  assign out_ch.sample_count = out_count_r;
  assign out_ch.accepted     = out_acc_r;

`ifndef SYNTHESIS
  logic [C-1:0] cur_shift;
  assign cur_shift = count_r >> lvl_r;

  // ripple only walks over occupied slots
  a_ripple_occupied: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == bmrm_pkg::ST_RIPPLE) |-> cur_shift[0])
    else $error("ripple on empty slot");

  // a store bumps the count by exactly one
  a_write_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == bmrm_pkg::ST_WRITE) |=> (count_r == C'($past(count_r) + 1'b1)))
    else $error("count not incremented on store");

  // divider answers only while waited for
  a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> (state_r == bmrm_pkg::ST_DIVIDE))
    else $error("unexpected divider done");

  // remainder below divisor
  a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> (div_rsp.rem < count_r))
    else $error("remainder not below count");

  // output word is only loaded into a free or draining register
  a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
    load_out |-> (!out_valid_r || out_ch.ready))
    else $error("output word overwritten");
`endif

endmodule

FILE: test/binary_merge_running_mean_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// binary_merge_running_mean_unit_tb
// Self-checking bench for the running mean unit. A directed table covers the
// sample extremes, clears, merge rounding and carries through several levels.
// A random stream follows, long enough to ripple up about nine levels. Each
// result word is checked against its row's hand-typed value or a bit-true model
// of the level store. Both channels idle at random, with one long output hold-off.
// ----------------------------------------------------------------------------
module binary_merge_running_mean_unit_tb;
  import bmrm_pkg::*;

  // one result word
  typedef struct packed {
    logic signed [MEAN_BITS-1:0] mean;
    logic [COUNT_BITS-1:0]       count;
    logic                        accepted;
  } mean_word_t;

  // one row of the directed table; known = result typed in by hand
  typedef struct packed {
    logic                        action;
    logic signed [IN_BITS-1:0]   sample;
    logic                        known;
    logic signed [MEAN_BITS-1:0] mean;
    logic [COUNT_BITS-1:0]       count;
    logic                        accepted;
  } dir_row_t;

  localparam int                    NUM_DIR    = 22;
  localparam int                    NUM_RAND   = 930;
  localparam int                    HOLD_AT    = 200;
  localparam int                    HOLD_LEN   = 400;
  localparam logic signed [31:0]    S_MAX      = 32'sh7FFF_FFFF;
  localparam logic signed [31:0]    S_MIN      = 32'sh8000_0000;
  localparam logic signed [47:0]    M_ZERO     = '0;
  localparam logic signed [47:0]    M_MIN      = 48'sh8000_0000_0000;
  localparam logic signed [47:0]    M_MAX_SAMP = 48'sh7FFF_FFFF_0000;
  localparam logic signed [47:0]    M_ONE      = 48'sh0000_0001_0000;
  localparam longint                ENTRY_HI   = (64'sd1 <<< (MEAN_BITS - 1)) - 1;
  localparam longint                ENTRY_LO   = -ENTRY_HI - 1;
  localparam logic [63:0]           FULL_COUNT =
    (LEVELS >= 32) ? 64'hFFFF_FFFF : ((64'd1 << LEVELS) - 64'd1);

  localparam dir_row_t DIR_ROWS [NUM_DIR] = '{
    '{ACT_CLEAR, 32'sd0,  1'b1, M_ZERO,     32'd0, 1'b1},
    '{ACT_ADD,   32'sd0,  1'b1, M_ZERO,     32'd1, 1'b1},
    '{ACT_CLEAR, 32'sd0,  1'b1, M_ZERO,     32'd0, 1'b1},
    '{ACT_ADD,   S_MAX,   1'b1, M_MAX_SAMP, 32'd1, 1'b1},
    '{ACT_ADD,   S_MIN,   1'b0, M_ZERO,     32'd0, 1'b0},
    '{ACT_CLEAR, 32'sd0,  1'b1, M_ZERO,     32'd0, 1'b1},
    '{ACT_ADD,   S_MIN,   1'b1, M_MIN,      32'd1, 1'b1},
    '{ACT_ADD,   S_MIN,   1'b0, M_ZERO,     32'd0, 1'b0},
    '{ACT_ADD,   S_MAX,   1'b0, M_ZERO,     32'd0, 1'b0},
    '{ACT_ADD,   -32'sd1, 1'b0, M_ZERO,     32'd0, 1'b0},
    '{ACT_ADD,   32'sd1,  1'b0, M_ZERO,     32'd0, 1'b0},
    '{ACT_ADD,   32'sd0,  1'b0, M_ZERO,     32'd0, 1'b0},
    '{ACT_ADD,   -32'sd1, 1'b0, M_ZERO,     32'd0, 1'b0},
    '{ACT_ADD,   32'sd0,  1'b0, M_ZERO,     32'd0, 1'b0},
    '{ACT_ADD,   32'sd3,  1'b0, M_ZERO,     32'd0, 1'b0},
    '{ACT_ADD,   -32'sd3, 1'b0, M_ZERO,     32'd0, 1'b0},
    '{ACT_ADD,   32'sh5555_5555, 1'b0, M_ZERO, 32'd0, 1'b0},
    '{ACT_ADD,   32'shAAAA_AAAA, 1'b0, M_ZERO, 32'd0, 1'b0},
    '{ACT_CLEAR, S_MAX,   1'b1, M_ZERO,     32'd0, 1'b1},
    '{ACT_ADD,   32'sd1,  1'b1, M_ONE,      32'd1, 1'b1},
    '{ACT_ADD,   32'sd2,  1'b0, M_ZERO,     32'd0, 1'b0},
    '{ACT_ADD,   -32'sd7, 1'b0, M_ZERO,     32'd0, 1'b0}
  };

  logic clk = 1'b0;
  logic rst_n;

  bmrm_in_if  in_ch ();
  bmrm_out_if out_ch ();

  binary_merge_running_mean_unit uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #2 clk = ~clk;

  // model state: partial means per level and the sample count
  logic signed [MEAN_BITS-1:0] part_mean [LEVELS];
  logic [COUNT_BITS-1:0]       total;

  mean_word_t expected_means [$];
  int bad_words    = 0;
  int words_seen   = 0;
  int num_adds     = 0;
  int num_clears   = 0;
  int deepest_lvl  = 0;
  int peak_count   = 0;
  int stall_cycles = 0;
  logic send_idle  = 1'b1;
  logic recv_idle  = 1'b1;
  logic hold_out   = 1'b0;

  // average of two equal-depth entries, round half up
  function automatic longint pair_avg(longint a, longint b);
    longint s;
    s = a + b + 1;
    return s >>> 1;
  endfunction

  // 2^d-weighted sum of occupied levels, divided by count, nearest/ties away
  function automatic logic signed [MEAN_BITS-1:0] weighted_mean();
    logic signed [127:0] acc;
    logic signed [127:0] w;
    logic [127:0]        mag;
    logic [127:0]        cnt;
    logic [127:0]        q;
    logic [127:0]        r;
    longint              v;
    logic                neg;
    acc = '0;
    if (total == 0) return '0;
    for (int d = 0; d < LEVELS && d < 32; d++) begin
      if (total[d]) begin
        v   = part_mean[d];
        w   = v;
        acc = acc + (w <<< d);
      end
    end
    neg = acc < 0;
    mag = neg ? -acc : acc;
    cnt = total;
    q   = mag / cnt;
    r   = mag % cnt;
    if (r >= cnt - r) q = q + 1;
    if (q > (128'd1 << (MEAN_BITS - 1))) q = 128'd1 << (MEAN_BITS - 1);
    if (!neg && q > 128'(ENTRY_HI)) q = 128'(ENTRY_HI);
    return neg ? -q[MEAN_BITS-1:0] : q[MEAN_BITS-1:0];
  endfunction

  // apply one word to the model and return the result it should produce
  function automatic mean_word_t advance_mean(logic act, logic signed [IN_BITS-1:0] smp);
    mean_word_t                    res;
    logic signed [SAMPLE_BITS-1:0] s;
    longint                        e;
    int                            d;
    res.accepted = 1'b1;
    if (act == ACT_CLEAR) begin
      total = '0;
      num_clears++;
    end else if (64'(total) >= FULL_COUNT) begin
      res.accepted = 1'b0;
    end else begin
      s = smp[SAMPLE_BITS-1:0];
      e = s;
      e = e * (64'sd1 <<< FRACTION_BITS);
      if (e > ENTRY_HI) e = ENTRY_HI;
      if (e < ENTRY_LO) e = ENTRY_LO;
      d = 0;
      while (d < LEVELS && d < 32 && total[d]) begin
        e = pair_avg(part_mean[d], e);
        d++;
      end
      if (d < LEVELS) part_mean[d] = e[MEAN_BITS-1:0];
      if (d > deepest_lvl) deepest_lvl = d;
      total = total + 1'b1;
      num_adds++;
      if (int'(total) > peak_count) peak_count = int'(total);
    end
    res.mean  = weighted_mean();
    res.count = total;
    return res;
  endfunction

  // drive one word at the falling edge, hold until taken
  task automatic send_word(logic act, logic signed [IN_BITS-1:0] smp, logic known,
                           mean_word_t typed);
    int         gap;
    mean_word_t exp_word;
    gap = send_idle ? $urandom_range(0, 9) : 0;
    if (gap > 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid  = 1'b1;
    in_ch.action = act;
    in_ch.sample = smp;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    exp_word = advance_mean(act, smp);
    expected_means.push_back(known ? typed : exp_word);
    @(negedge clk);
  endtask

  // random sample: extremes, small values or full range
  function automatic logic signed [IN_BITS-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0:       return S_MAX;
      1:       return S_MIN;
      2:       return $signed($urandom_range(0, 16)) - 8;
      default: return $urandom;
    endcase
  endfunction

  // result side: random hold-off per word, plus one long stall on request
  initial begin
    int wait_cyc;
    out_ch.ready = 1'b0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      if (hold_out) begin
        out_ch.ready = 1'b0;
        repeat (HOLD_LEN) begin
          @(negedge clk);
          stall_cycles++;
        end
        hold_out = 1'b0;
      end
      wait_cyc = recv_idle ? $urandom_range(0, 9) : 0;
      if (wait_cyc > 0) begin
        out_ch.ready = 1'b0;
        repeat (wait_cyc) @(negedge clk);
      end
      out_ch.ready = 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
      @(negedge clk);
    end
  end

  // compare each result word with the oldest expectation
  always @(posedge clk) begin
    mean_word_t exp_word;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      words_seen++;
      if (expected_means.size() == 0) begin
        bad_words++;
        if (bad_words <= 10)
          $display("ERROR: unexpected word mean=%0d count=%0d accepted=%0b",
                   out_ch.mean, out_ch.sample_count, out_ch.accepted);
      end else begin
        exp_word = expected_means.pop_front();
        if (out_ch.mean !== exp_word.mean || out_ch.sample_count !== exp_word.count ||
            out_ch.accepted !== exp_word.accepted) begin
          bad_words++;
          if (bad_words <= 10)
            $display({"ERROR: word %0d exp mean=%0d count=%0d acc=%0b, ",
                      "got mean=%0d count=%0d acc=%0b"},
                     words_seen, exp_word.mean, exp_word.count, exp_word.accepted,
                     out_ch.mean, out_ch.sample_count, out_ch.accepted);
        end
      end
    end
  end

  // watchdog
  initial begin
    #2_000_000;
    $display("binary_merge_running_mean_unit test failed");
    $finish;
  end

  // reset, directed table, random stream, drain
  initial begin
    mean_word_t typed;
    logic       act;
    in_ch.valid  = 1'b0;
    in_ch.action = ACT_ADD;
    in_ch.sample = '0;
    rst_n        = 1'b0;
    total        = '0;
    for (int d = 0; d < LEVELS; d++) part_mean[d] = '0;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    for (int i = 0; i < NUM_DIR; i++) begin
      typed.mean     = DIR_ROWS[i].mean;
      typed.count    = DIR_ROWS[i].count;
      typed.accepted = DIR_ROWS[i].accepted;
      send_word(DIR_ROWS[i].action, DIR_ROWS[i].sample, DIR_ROWS[i].known, typed);
    end

    typed = '0;
    for (int i = 0; i < NUM_RAND; i++) begin
      // new idling phase every 64 words; back-to-back offers during the hold
      if (i % 64 == 0) begin
        send_idle = $urandom_range(0, 2) != 0;
        recv_idle = $urandom_range(0, 2) != 0;
      end
      if (i == HOLD_AT) begin
        send_idle = 1'b0;
        hold_out  = 1'b1;
      end
      // frequent clears early for short runs, rare later to reach deep levels
      if (i < 400) act = ($urandom_range(0, 29) == 0) ? ACT_CLEAR : ACT_ADD;
      else         act = ($urandom_range(0, 299) == 0) ? ACT_CLEAR : ACT_ADD;
      send_word(act, pick_sample(), 1'b0, typed);
    end
    in_ch.valid = 1'b0;

    while (expected_means.size() != 0) @(posedge clk);
    repeat (120) @(posedge clk);

    $display("Checked %0d words: %0d adds, %0d clears, count up to %0d, carry depth %0d",
             words_seen, num_adds, num_clears, peak_count, deepest_lvl);
    $display("Output held off for %0d cycles; %0d mismatches", stall_cycles, bad_words);
    if (bad_words == 0 && expected_means.size() == 0) begin
      $display("binary_merge_running_mean_unit test passed");
    end else begin
      $display("binary_merge_running_mean_unit test failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/bmrm_pkg.sv
rtl/bmrm_ifs.sv
rtl/bmrm_ram.sv
rtl/bmrm_div.sv
rtl/binary_merge_running_mean_unit.sv
test/binary_merge_running_mean_unit_tb.sv
